/* src/capm_pkg.sv */
// package for the cascaded attitude controller and motor mixer
// types, constants and sequencer state codes; no dependencies
`default_nettype none
package capm_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NREG = 5;
  localparam int REG_W = 48;
  localparam int IDX_W = 3;
  localparam int RATE_DIV = 100;
  localparam int MIX_SCALE = 10;
  localparam int CLAMP_UNITS = 300;

  typedef enum logic [2:0] {
    REG_OUTER_KP = 3'd0,
    REG_OUTER_KI = 3'd1,
    REG_INNER_KP = 3'd2,
    REG_INNER_KI = 3'd3,
    REG_INNER_KD = 3'd4
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_EO, ST_OI, ST_RO1, ST_RO2, ST_EI, ST_II, ST_DSUB, ST_DIV,
    ST_DSAT, ST_RI1, ST_RI2, ST_RI3, ST_NEXT, ST_MIX, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage
`default_nettype wire

/* src/capm_if.sv */
// valid/ready channel interfaces for the controller
// depends on nothing
`default_nettype none
interface capm_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] target_x, target_y, target_z;
  logic signed [31:0] angle_x, angle_y, angle_z;
  logic signed [15:0] rate_raw_x, rate_raw_y, rate_raw_z;
  logic [15:0] throttle;
  logic [15:0] step_time;
  modport source (output valid, target_x, target_y, target_z, angle_x, angle_y, angle_z,
                  rate_raw_x, rate_raw_y, rate_raw_z, throttle, step_time, input ready);
  modport sink (input valid, target_x, target_y, target_z, angle_x, angle_y, angle_z,
                rate_raw_x, rate_raw_y, rate_raw_z, throttle, step_time, output ready);
endinterface

interface capm_out_if;
  logic valid;
  logic ready;
  logic signed [23:0] motor_up, motor_down, motor_left, motor_right;
  modport source (output valid, motor_up, motor_down, motor_left, motor_right, input ready);
  modport sink (input valid, motor_up, motor_down, motor_left, motor_right, output ready);
endinterface

interface capm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/capm_div.sv */
// restoring signed divider, one quotient bit a cycle, truncating toward zero
// uses capm_pkg for the control struct
`default_nettype none
module capm_div
  import capm_pkg::*;
#(
  parameter int NW = 50
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire div_ctl_t             ctl_in,
  input  wire logic signed [NW-1:0] num,
  input  wire logic [15:0]          den,
  output div_ctl_t                  ctl_out,
  output logic signed [NW-1:0]      quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [16:0]   rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt, busy_r, busy_nxt;
  logic [17:0]   trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    busy_nxt = busy_r;
    trial = '0;
    if (ctl_in.start) begin
      neg_nxt = num[NW-1];
      q_nxt = num[NW-1] ? NW'(-num) : NW'(num);
      rem_nxt = '0;
      cnt_nxt = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in next dividend bit, subtract if it fits
      trial = {rem_r, q_r[NW-1]} - {2'b00, den};
      if (!trial[17]) begin
        rem_nxt = trial[16:0];
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[15:0], q_r[NW-1]};
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign quo = neg_r ? NW'(-$signed(q_r)) : $signed(q_r);
  assign ctl_out.busy = busy_r;
  assign ctl_out.start = 1'b0;
endmodule
`default_nettype wire

/* src/capm_core.sv */
// sequencer and shared multiply/accumulate datapath for the three axes and mixer
// uses capm_pkg, capm_div and the channel interfaces
`default_nettype none
module capm_core
  import capm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  capm_in_if.sink          in_ch,
  capm_out_if.source       out_ch,
  capm_cfg_if.sink         cfg_ch
);
  localparam int DW = 50;
  localparam longint LIM_RAW = longint'(CLAMP_UNITS) <<< FRAC_BITS;
  localparam longint LIM = (LIM_RAW > 64'sd2147483647) ? 64'sd2147483647 : LIM_RAW;
  localparam longint I32MAX = 64'sd2147483647;
  localparam longint I32MIN = -64'sd2147483648;
  // floor(a / 100) = (a * RQ_MUL) >> RQ_SH for every a below 43690
  localparam int RQ_MUL = 5243;
  localparam int RQ_SH = 19;
  // floor(r * 2^F / 100) = (r * RF_MUL) >> RF_SH for every remainder r below 100
  localparam int RF_SH = 14;
  localparam longint RF_MUL =
    ((64'sd1 <<< (FRAC_BITS + RF_SH)) + longint'(RATE_DIV) - 64'sd1) / longint'(RATE_DIV);

  state_t state_r, state_nxt;
  logic [47:0] regs_r [NREG];
  logic signed [31:0] oi_r [3], ii_r [3], le_r [3];
  logic signed [31:0] res_r [3];
  logic [1:0] ax_r, ax_nxt;
  logic [1:0] mk_r, mk_nxt;
  logic signed [31:0] eo_r, eo_nxt, ei_r, ei_nxt, d_r, d_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [23:0] mot_r [4];
  logic signed [23:0] mot_nxt;
  logic out_v_r;
  logic [15:0] dt_r;

  // latched request
  logic signed [31:0] tgt_r [3], ang_r [3];
  logic signed [15:0] raw_r [3];
  logic [15:0] thr_r;

  div_ctl_t dctl, dstat;
  logic signed [DW-1:0] dnum_r, dnum_nxt, dquo;

  // shared multiplier operands
  logic signed [31:0] ma;
  logic signed [16:0] mb;
  logic signed [48:0] prod;
  logic signed [15:0] g;
  logic [2:0] greg;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > I32MAX) return 32'sh7fffffff;
    if (x < I32MIN) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] clampi(input logic signed [63:0] x);
    if (x > LIM) return 32'(LIM);
    if (x < -LIM) return 32'(-LIM);
    return x[31:0];
  endfunction

  assign g = $signed(regs_r[greg][16*ax_r +: 16]);
  assign prod = ma * mb;

  logic signed [16:0] rsx;
  logic [16:0] rmag;
  logic [8:0] rq_r, rq_nxt;
  logic [6:0] rr_r, rr_nxt;
  logic signed [63:0] rate_r, rate_nxt;
  logic signed [63:0] rmix;
  logic signed [63:0] mixv;
  logic signed [63:0] mround;
  logic signed [63:0] mv10;
  logic signed [63:0] half;

  always_comb begin
    // counts * 2^F / 100 toward zero: quotient and remainder of |counts| by 100,
    // then the remainder's share of 2^F, spread over three states
    rsx = {raw_r[ax_r][15], raw_r[ax_r]};
    rmag = rsx[16] ? 17'(-rsx) : 17'(rsx);
    rmix = (64'(rq_r) <<< FRAC_BITS) + ((64'(rr_r) * RF_MUL) >>> RF_SH);
  end

  always_comb begin
    state_nxt = state_r;
    ax_nxt = ax_r;
    mk_nxt = mk_r;
    eo_nxt = eo_r;
    ei_nxt = ei_r;
    d_nxt = d_r;
    acc_nxt = acc_r;
    dnum_nxt = dnum_r;
    rq_nxt = rq_r;
    rr_nxt = rr_r;
    rate_nxt = rate_r;
    dctl = '0;
    greg = REG_OUTER_KP;
    ma = '0;
    mb = '0;
    mixv = '0;
    mv10 = '0;
    mround = '0;
    mot_nxt = '0;
    half = 64'sd1 <<< (FRAC_BITS - 1);
    unique case (state_r)
      ST_IDLE: if (in_ch.valid) begin
        state_nxt = ST_EO;
        ax_nxt = '0;
      end
      ST_EO: begin
        eo_nxt = sat32(64'(tgt_r[ax_r]) - 64'(ang_r[ax_r]));
        rq_nxt = 9'((32'(rmag) * 32'(RQ_MUL)) >> RQ_SH);
        state_nxt = ST_OI;
      end
      ST_OI: begin
        ma = eo_r; mb = $signed({1'b0, dt_r});
        rr_nxt = 7'(rmag - 17'(rq_r) * 17'(RATE_DIV));
        state_nxt = ST_RO1;
      end
      ST_RO1: begin
        greg = REG_OUTER_KP; ma = eo_r; mb = 17'(g);
        acc_nxt = 64'(prod) >>> 8;
        rate_nxt = rsx[16] ? -rmix : rmix;
        state_nxt = ST_RO2;
      end
      ST_RO2: begin
        greg = REG_OUTER_KI; ma = oi_r[ax_r]; mb = 17'(g);
        acc_nxt = acc_r + (64'(prod) >>> 8);
        state_nxt = ST_EI;
      end
      ST_EI: begin
        ei_nxt = sat32(64'(sat32(acc_r)) - rate_r);
        state_nxt = ST_II;
      end
      ST_II: begin
        ma = ei_r; mb = $signed({1'b0, dt_r});
        state_nxt = ST_DSUB;
      end
      ST_DSUB: begin
        dnum_nxt = DW'(64'(ei_r) - 64'(le_r[ax_r])) <<< 16;
        dctl.start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: if (!dstat.busy) state_nxt = ST_DSAT;
      ST_DSAT: begin
        d_nxt = sat32(64'(dquo));
        state_nxt = ST_RI1;
      end
      ST_RI1: begin
        greg = REG_INNER_KP; ma = ei_r; mb = 17'(g);
        acc_nxt = 64'(prod) >>> 8;
        state_nxt = ST_RI2;
      end
      ST_RI2: begin
        greg = REG_INNER_KI; ma = ii_r[ax_r]; mb = 17'(g);
        acc_nxt = acc_r + (64'(prod) >>> 8);
        state_nxt = ST_RI3;
      end
      ST_RI3: begin
        greg = REG_INNER_KD; ma = d_r; mb = 17'(g);
        acc_nxt = acc_r + (64'(prod) >>> 8);
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if (ax_r == 2'd2) begin
          state_nxt = ST_MIX;
          mk_nxt = '0;
        end else begin
          ax_nxt = ax_r + 1'b1;
          state_nxt = ST_EO;
        end
      end
      ST_MIX: begin
        unique case (mk_r)
          2'd0: mixv = 64'(res_r[0]) - 64'(res_r[1]) + 64'(res_r[2]);
          2'd1: mixv = -64'(res_r[0]) + 64'(res_r[1]) + 64'(res_r[2]);
          2'd2: mixv = 64'(res_r[0]) + 64'(res_r[1]) - 64'(res_r[2]);
          default: mixv = -64'(res_r[0]) - 64'(res_r[1]) - 64'(res_r[2]);
        endcase
        mv10 = (mixv <<< 3) + (mixv <<< 1);
        // round half away from zero
        if (mv10 >= 0) mround = (mv10 + half) >>> FRAC_BITS;
        else mround = -((-mv10 + half) >>> FRAC_BITS);
        mround = mround + 64'($unsigned(thr_r));
        if (mround > 64'sd8388607) mot_nxt = 24'sh7fffff;
        else if (mround < -64'sd8388608) mot_nxt = 24'sh800000;
        else mot_nxt = mround[23:0];
        mk_nxt = mk_r + 1'b1;
        if (mk_r == 2'd3) state_nxt = ST_OUT;
      end
      ST_OUT: if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // the divider takes the numerator in the same cycle as its start
  capm_div #(.NW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .ctl_in(dctl), .num(dnum_nxt),
    .den(dt_r), .ctl_out(dstat), .quo(dquo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < NREG; i++) regs_r[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        oi_r[i] <= '0; ii_r[i] <= '0; le_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.index < IDX_W'(NREG))
        regs_r[cfg_ch.index] <= cfg_ch.data;
      if (state_r == ST_OI)
        oi_r[ax_r] <= clampi(64'(oi_r[ax_r]) + (64'(prod) >>> 16));
      if (state_r == ST_II)
        ii_r[ax_r] <= clampi(64'(ii_r[ax_r]) + (64'(prod) >>> 16));
      if (state_r == ST_NEXT) le_r[ax_r] <= ei_r;
    end
    ax_r <= ax_nxt;
    mk_r <= mk_nxt;
    eo_r <= eo_nxt;
    ei_r <= ei_nxt;
    d_r <= d_nxt;
    acc_r <= acc_nxt;
    dnum_r <= dnum_nxt;
    rq_r <= rq_nxt;
    rr_r <= rr_nxt;
    rate_r <= rate_nxt;
    if (state_r == ST_RI3) res_r[ax_r] <= sat32(acc_nxt);
    if (state_r == ST_MIX) mot_r[mk_r] <= mot_nxt;
    if (state_r == ST_IDLE && in_ch.valid) begin
      tgt_r[0] <= in_ch.target_x; tgt_r[1] <= in_ch.target_y; tgt_r[2] <= in_ch.target_z;
      ang_r[0] <= in_ch.angle_x; ang_r[1] <= in_ch.angle_y; ang_r[2] <= in_ch.angle_z;
      raw_r[0] <= in_ch.rate_raw_x; raw_r[1] <= in_ch.rate_raw_y;
      raw_r[2] <= in_ch.rate_raw_z;
      thr_r <= in_ch.throttle;
      dt_r <= (in_ch.step_time == 16'd0) ? 16'd1 : in_ch.step_time;
    end
  end

  assign out_v_r = (state_r == ST_OUT);
  assign in_ch.ready = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_v_r;
  assign out_ch.motor_up = mot_r[0];
  assign out_ch.motor_down = mot_r[1];
  assign out_ch.motor_left = mot_r[2];
  assign out_ch.motor_right = mot_r[3];
endmodule
`default_nettype wire

/* src/cascaded_attitude_pid_mixer.sv */
// Cascaded attitude controller with four-motor mixer. Each axis runs a handful
// of multiply steps on one shared 32x17 multiplier and a bit-serial divide for
// the derivative term. in_ready is high only when idle, and the result waits in
// out_* until taken. Configuration writes are always ready and must be made
// while idle.
`default_nettype none
module cascaded_attitude_pid_mixer
  import capm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  capm_in_if.sink    in_ch,
  capm_out_if.source out_ch,
  capm_cfg_if.sink   cfg_ch
);
  capm_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );
endmodule
`default_nettype wire

/* src/capm_checker.sv */
// port-level checks on the controller, bound to the top level
// uses the channel interfaces
`default_nettype none
module capm_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after request");
  a_no_quick_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind cascaded_attitude_pid_mixer capm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
`default_nettype wire
